/* sv/gain_mixer_saturating_core_defines.svh */
// ----------------------------------------------------------------------------
// gain_mixer_saturating_core_defines
// Assertion macros used by the checker gms_checker.
// ----------------------------------------------------------------------------
`ifndef GAIN_MIXER_SATURATING_CORE_DEFINES_SVH
`define GAIN_MIXER_SATURATING_CORE_DEFINES_SVH

// clocked assertion, switched off while reset is asserted
`define GMS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error(msg);

// clocked assertion that also holds through reset
`define GMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
	else $error(msg);

`endif

/* sv/gms_pkg.sv */
// ----------------------------------------------------------------------------
// gms_pkg
// Types, constants and helpers of the saturating gain mixer.
// ----------------------------------------------------------------------------
package gms_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int GAIN_BITS    = 16;
	localparam int CH_BITS      = 3;
	localparam int NUM_CHANNELS = 5;
	localparam int GAIN_REGS    = 5;
	localparam int ACC_BITS     = 24;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int FRAC_BITS    = 15;
	localparam int MUL_BITS     = 18;
	localparam int PROD_BITS    = 2 * MUL_BITS;

	localparam logic [GAIN_BITS-1:0] UNITY = GAIN_BITS'(32768);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MASTER_GAIN    = 3'd0,
		REG_MASTER_MUTE    = 3'd1,
		REG_CHAN_MUTE_MASK = 3'd2,
		REG_MUSIC_GAIN     = 3'd3,
		REG_EFFECTS_GAIN   = 3'd4,
		REG_VOICE_GAIN     = 3'd5,
		REG_AMBIENT_GAIN   = 3'd6,
		REG_INTERFACE_GAIN = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [GAIN_BITS-1:0]                master_gain;
		logic                                master_mute;
		logic [GAIN_REGS-1:0]                mute_mask;
		logic [GAIN_REGS-1:0][GAIN_BITS-1:0] chan_gain;
	} cfg_t;

	typedef enum logic [1:0] {
		MUL_SRC    = 2'd0,
		MUL_MASTER = 2'd1,
		MUL_SAMPLE = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     start;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_en;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

	function automatic logic [GAIN_BITS-1:0] sat_unity(input logic [GAIN_BITS-1:0] g);
		return (g > UNITY) ? UNITY : g;
	endfunction

endpackage

/* sv/gain_mixer_saturating_core.sv */
// A source word is taken in S_IDLE and passes S_MUL2, S_MUL3 and S_ACC before the next
// is taken; the shared multiplier makes three successive passes (source x channel
// gain, x master gain, x sample); S_ACC then accumulates, or emits the mix of the last
// word once the output register is free, where it waits while the next word is taken.
// Reset (arst_n low): sequencer idle, output empty, accumulator zero, gains unity, unmuted.
// ----------------------------------------------------------------------------
// gain_mixer_saturating_core
// Multichannel mixer: per-source, channel and master gain, saturating sum,
// clipped output with clip flag and master mute.
// ----------------------------------------------------------------------------
module gain_mixer_saturating_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [gms_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [gms_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [gms_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [gms_pkg::GAIN_BITS-1:0]          source_gain,
	input  logic [gms_pkg::CH_BITS-1:0]            channel,
	input  logic                                   present,
	input  logic                                   last_source,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [gms_pkg::SAMPLE_BITS-1:0] mixed_sample,
	output logic                                   clipped
);
	import gms_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	gms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	gms_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg          (cfg),
		.sample       (sample),
		.source_gain  (source_gain),
		.channel      (channel),
		.present      (present),
		.last_source  (last_source),
		.mixed_sample (mixed_sample),
		.clipped      (clipped)
	);

endmodule

/* sv/gms_cfg_regs.sv */
// ----------------------------------------------------------------------------
// gms_cfg_regs
// Master and channel gain / mute registers behind the write port.
// ----------------------------------------------------------------------------
module gms_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [gms_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [gms_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output gms_pkg::cfg_t                       cfg
);
	import gms_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_gain <= UNITY;
			cfg_q.master_mute <= 1'b0;
			cfg_q.mute_mask   <= '0;
			for (int i = 0; i < GAIN_REGS; i++)
				cfg_q.chan_gain[i] <= UNITY;
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				REG_MASTER_GAIN:    cfg_q.master_gain  <= cfg_data[GAIN_BITS-1:0];
				REG_MASTER_MUTE:    cfg_q.master_mute  <= cfg_data[0];
				REG_CHAN_MUTE_MASK: cfg_q.mute_mask    <= cfg_data[GAIN_REGS-1:0];
				REG_MUSIC_GAIN:     cfg_q.chan_gain[0] <= cfg_data[GAIN_BITS-1:0];
				REG_EFFECTS_GAIN:   cfg_q.chan_gain[1] <= cfg_data[GAIN_BITS-1:0];
				REG_VOICE_GAIN:     cfg_q.chan_gain[2] <= cfg_data[GAIN_BITS-1:0];
				REG_AMBIENT_GAIN:   cfg_q.chan_gain[3] <= cfg_data[GAIN_BITS-1:0];
				REG_INTERFACE_GAIN: cfg_q.chan_gain[4] <= cfg_data[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/gms_ctrl.sv */
// ----------------------------------------------------------------------------
// gms_ctrl
// Sequencer: three passes through the shared multiplier, then accumulate
// or emit. Owns the output valid flag.
// ----------------------------------------------------------------------------
module gms_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  gms_pkg::status_t status,
	output gms_pkg::cmd_t    cmd
);
	import gms_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL2 = 4'b0010,
		S_MUL3 = 4'b0100,
		S_ACC  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = MUL_SRC;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start  = 1'b1;
					cmd.mul_en = 1'b1;
					state_d    = S_MUL2;
				end
			end
			S_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MASTER;
				state_d     = S_MUL3;
			end
			S_MUL3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SAMPLE;
				state_d     = S_ACC;
			end
			S_ACC: begin
				if (!status.last) begin
					cmd.acc_en = 1'b1;
					state_d    = S_IDLE;
				end else if (!out_valid_q || out_ready) begin
					// output register free this cycle: emit and clear the mix
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* sv/gms_datapath.sv */
// ----------------------------------------------------------------------------
// gms_datapath
// Input word register, one shared 18x18 signed multiplier with product
// register, saturating accumulator and clipped output register.
// ----------------------------------------------------------------------------
module gms_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gms_pkg::cmd_t                       cmd,
	output gms_pkg::status_t                    status,
	input  gms_pkg::cfg_t                       cfg,
	input  logic signed [gms_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [gms_pkg::GAIN_BITS-1:0]       source_gain,
	input  logic [gms_pkg::CH_BITS-1:0]         channel,
	input  logic                                present,
	input  logic                                last_source,
	output logic signed [gms_pkg::SAMPLE_BITS-1:0] mixed_sample,
	output logic                                clipped
);
	import gms_pkg::*;

	localparam logic signed [ACC_BITS:0] ACC_MAX = (ACC_BITS+1)'((1 << (ACC_BITS-1)) - 1);
	localparam logic signed [ACC_BITS:0] ACC_MIN = -(ACC_BITS+1)'(1 << (ACC_BITS-1));
	localparam logic signed [ACC_BITS-1:0] OUT_MAX =
		ACC_BITS'((1 << (SAMPLE_BITS-1)) - 1);
	localparam logic signed [ACC_BITS-1:0] OUT_MIN = -ACC_BITS'(1 << (SAMPLE_BITS-1));

	logic signed [SAMPLE_BITS-1:0]  sample_q;
	logic                           zero_q;
	logic                           last_q;
	logic signed [PROD_BITS-1:0]    prod_q;
	logic signed [ACC_BITS-1:0]     acc_q;
	logic signed [SAMPLE_BITS-1:0]  mixed_q;
	logic                           clipped_q;

	logic                           has_gain;
	logic [GAIN_BITS-1:0]           cg;
	logic [GAIN_BITS-1:0]           g_part;
	logic [GAIN_BITS-1:0]           g_eff;
	logic signed [MUL_BITS-1:0]     mul_a, mul_b;
	logic signed [PROD_BITS-1:0]    prod;
	logic signed [SAMPLE_BITS:0]    contrib;
	logic signed [ACC_BITS:0]       sum;
	logic signed [ACC_BITS-1:0]     sum_sat;

	// channel lookup straight from the input word at accept
	assign has_gain = (int'(channel) < NUM_CHANNELS) && (int'(channel) < GAIN_REGS);
	assign cg       = has_gain ? sat_unity(cfg.chan_gain[channel]) : UNITY;

	// gains never exceed 2^31 in the product, so bits [30:15] hold the Q1.15 result
	assign g_part = prod_q[FRAC_BITS+GAIN_BITS-1:FRAC_BITS];
	assign g_eff  = (g_part > UNITY) ? UNITY : g_part;

	always_comb begin
		case (cmd.mul_sel)
			MUL_SRC: begin
				mul_a = MUL_BITS'($unsigned(source_gain));
				mul_b = MUL_BITS'($unsigned(cg));
			end
			MUL_MASTER: begin
				mul_a = MUL_BITS'($unsigned(g_part));
				mul_b = MUL_BITS'($unsigned(sat_unity(cfg.master_gain)));
			end
			MUL_SAMPLE: begin
				mul_a = MUL_BITS'(sample_q);
				mul_b = zero_q ? '0 : MUL_BITS'($unsigned(g_eff));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// arithmetic shift by 15 rounds toward minus infinity
	assign contrib = prod_q[FRAC_BITS+SAMPLE_BITS:FRAC_BITS];
	assign sum     = (ACC_BITS+1)'(acc_q) + (ACC_BITS+1)'(contrib);

	always_comb begin
		if (sum > ACC_MAX)
			sum_sat = ACC_MAX[ACC_BITS-1:0];
		else if (sum < ACC_MIN)
			sum_sat = ACC_MIN[ACC_BITS-1:0];
		else
			sum_sat = sum[ACC_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sample_q <= sample;
			zero_q   <= !present || (has_gain && cfg.mute_mask[channel]);
			last_q   <= last_source;
		end
		if (cmd.mul_en)
			prod_q <= prod;
		if (cmd.emit) begin
			if (cfg.master_mute) begin
				mixed_q   <= '0;
				clipped_q <= 1'b0;
			end else if (sum_sat > OUT_MAX) begin
				mixed_q   <= OUT_MAX[SAMPLE_BITS-1:0];
				clipped_q <= 1'b1;
			end else if (sum_sat < OUT_MIN) begin
				mixed_q   <= OUT_MIN[SAMPLE_BITS-1:0];
				clipped_q <= 1'b1;
			end else begin
				mixed_q   <= sum_sat[SAMPLE_BITS-1:0];
				clipped_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_q <= '0;
		else if (cmd.emit)
			acc_q <= '0;
		else if (cmd.acc_en)
			acc_q <= sum_sat;
	end

	assign status.last  = last_q;
	assign mixed_sample = mixed_q;
	assign clipped      = clipped_q;

endmodule

/* sv/gms_checker.sv */
// ----------------------------------------------------------------------------
// gms_checker
// Port-level checks of the mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "gain_mixer_saturating_core_defines.svh"

module gms_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic signed [gms_pkg::SAMPLE_BITS-1:0] mixed_sample,
	input  logic                                   clipped
);
	import gms_pkg::*;

	// stalled result word holds
	`GMS_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(mixed_sample) && $stable(clipped), "result word changed while stalled")

	// sequencer is busy right after taking a word
	`GMS_ASSERT(a_busy, clk, arst_n, in_valid && in_ready |=> !in_ready, "input taken again during the multiply passes")

	// no result can appear during the multiply passes of a word
	`GMS_ASSERT(a_no_early, clk, arst_n, in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid), "result before accumulate")

	// a clipped word sits at one of the rails
	`GMS_ASSERT_ALWAYS(a_clip_rail, clk, out_valid && clipped |-> mixed_sample == 16'sh7fff || mixed_sample == -16'sh8000, "clip flag without rail value")

endmodule

bind gain_mixer_saturating_core gms_checker u_gms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.mixed_sample (mixed_sample),
	.clipped      (clipped)
);
